>>> hw/rtl/tpst_pkg.sv
// Package for the two pin similarity transform.
// Status codes, register indexes and pipeline control types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpst_pkg;

  localparam int unsigned RegIdxW = 3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSET = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_LOC_A_X = 3'd0,
    REG_LOC_A_Y = 3'd1,
    REG_LOC_B_X = 3'd2,
    REG_LOC_B_Y = 3'd3,
    REG_CUR_A_X = 3'd4,
    REG_CUR_A_Y = 3'd5,
    REG_CUR_B_X = 3'd6,
    REG_CUR_B_Y = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic    valid;
    status_e status;
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/two_pin_similarity_transform.sv
// Two pin similarity transform, top level: config registers, pipeline, output queue.
// Depends on tpst_pkg, tpst_front, tpst_div and tpst_skid.
//
// Usage: write the eight pin coordinates on the cfg channel (index 0..7: local a x,y,
// local b x,y, current a x,y, current b x,y), then stream points on s_axis. tuser bit 0
// picks the direction (0 local to current, 1 current to local). Each point yields one
// result on m_axis: mapped x and y in tdata, status in tuser (ok, pin unset, zero pin
// spacing, saturated).
// Throughput is one point per cycle while the output queue is not full. An accepted
// point passes six stages of differences and products, a divider input stage,
// COORD_WIDTH + 3 divider stages at one quotient bit each, rounding, and the output
// queue, which also takes the final add and clamp.
// Reset clears all pipeline valid bits and sets every pin to the minimum value (unset).
// A stalled receiver fills the two-entry output queue; once it is full the whole
// pipeline holds and s_axis_tready drops, nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module two_pin_similarity_transform #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tpst_pkg::RegIdxW-1:0]         cfg_index_i,
  input  logic [COORD_WIDTH-1:0]               cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x, point_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // operation
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // mapped_x, mapped_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                           m_axis_tuser
);
  import tpst_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DATAW = ((2 * CW + 7) / 8) * 8;
  localparam int unsigned QB    = CW + 4;
  localparam int unsigned SW    = QB + 1;
  localparam int unsigned AW    = SW + 1;
  localparam int unsigned OW    = 2 * CW + 2;
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  logic [7:0][CW-1:0] pins_q;
  logic               en, full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) pins_q[i] <= CMIN;
    end else if (cfg_valid_i) begin
      pins_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign en            = !full;
  assign s_axis_tready = en;

  ctl_t            f_ctl, d_ctl;
  logic            f_xn, f_yn, d_xn, d_yn;
  logic [3*CW+3:0] f_xm, f_ym;
  logic [2*CW:0]   f_den;
  logic [CW-1:0]   f_dax, f_day, d_dax, d_day;
  logic [QB-1:0]   d_xm, d_ym;

  tpst_front #(.CW(CW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .op_i     (s_axis_tuser),
    .px_i     (s_axis_tdata[CW-1:0]),
    .py_i     (s_axis_tdata[2*CW-1:CW]),
    .pins_i   (pins_q),
    .ctl_o    (f_ctl),
    .nx_neg_o (f_xn),
    .nx_mag_o (f_xm),
    .ny_neg_o (f_yn),
    .ny_mag_o (f_ym),
    .den_o    (f_den),
    .dax_o    (f_dax),
    .day_o    (f_day)
  );

  tpst_div #(.CW(CW)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (f_ctl),
    .nx_neg_i (f_xn),
    .nx_mag_i (f_xm),
    .ny_neg_i (f_yn),
    .ny_mag_i (f_ym),
    .den_i    (f_den),
    .dax_i    (f_dax),
    .day_i    (f_day),
    .ctl_o    (d_ctl),
    .x_neg_o  (d_xn),
    .x_mag_o  (d_xm),
    .y_neg_o  (d_yn),
    .y_mag_o  (d_ym),
    .dax_o    (d_dax),
    .day_o    (d_day)
  );

  logic signed [SW-1:0] qsx, qsy;
  logic signed [AW-1:0] sumx, sumy;
  logic signed [CW-1:0] rx, ry;
  logic                 satx, saty;
  status_e              st;
  logic [OW-1:0]        out_d, out_q;

  always_comb begin
    qsx  = d_xn ? -signed'(SW'(d_xm)) : signed'(SW'(d_xm));
    qsy  = d_yn ? -signed'(SW'(d_ym)) : signed'(SW'(d_ym));
    sumx = AW'(qsx) + AW'(signed'(d_dax));
    sumy = AW'(qsy) + AW'(signed'(d_day));
    satx = 1'b1;
    saty = 1'b1;
    if (sumx > AW'(CMAX)) rx = CMAX;
    else if (sumx < AW'(CMIN)) rx = CMIN;
    else begin
      rx   = CW'(sumx);
      satx = 1'b0;
    end
    if (sumy > AW'(CMAX)) ry = CMAX;
    else if (sumy < AW'(CMIN)) ry = CMIN;
    else begin
      ry   = CW'(sumy);
      saty = 1'b0;
    end
    st = d_ctl.status;
    if (st != ST_OK) begin
      rx = CMIN;
      ry = CMIN;
    end else if (satx || saty) begin
      st = ST_SAT;
    end
    out_d = {st, ry, rx};
  end

  tpst_skid #(.W(OW)) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && d_ctl.valid),
    .data_i  (out_d),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_q)
  );

  assign m_axis_tdata = DATAW'(out_q[2*CW-1:0]);
  assign m_axis_tuser = out_q[OW-1:2*CW];

`ifndef SYNTHESIS
  a_unset_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_UNSET) |->
      (m_axis_tdata[CW-1:0] == CMIN && m_axis_tdata[2*CW-1:CW] == CMIN))
    else $error("unset status without minimum outputs");
  a_zero_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_ZERO) |->
      (m_axis_tdata[CW-1:0] == CMIN && m_axis_tdata[2*CW-1:CW] == CMIN))
    else $error("zero spacing status without minimum outputs");
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_SAT) |->
      (m_axis_tdata[CW-1:0] == CMIN || m_axis_tdata[CW-1:0] == CMAX ||
       m_axis_tdata[2*CW-1:CW] == CMIN || m_axis_tdata[2*CW-1:CW] == CMAX))
    else $error("saturated status without a clamped coordinate");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tpst_front.sv
// Front of the transform pipeline: pin selection, differences, complex products.
// Six stages, ends in numerator magnitudes and the spacing denominator. Uses tpst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpst_front #(
  parameter int unsigned CW = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic                    op_i,
  input  logic [CW-1:0]           px_i,
  input  logic [CW-1:0]           py_i,
  input  logic [7:0][CW-1:0]      pins_i,
  output tpst_pkg::ctl_t          ctl_o,
  output logic                    nx_neg_o,
  output logic [3*CW+3:0]         nx_mag_o,
  output logic                    ny_neg_o,
  output logic [3*CW+3:0]         ny_mag_o,
  output logic [2*CW:0]           den_o,
  output logic [CW-1:0]           dax_o,
  output logic [CW-1:0]           day_o
);
  import tpst_pkg::*;

  localparam int unsigned D    = CW + 1;
  localparam int unsigned PW   = 2 * D;
  localparam int unsigned QW   = 2 * D + 1;
  localparam int unsigned LW   = D + 1;
  localparam int unsigned HW   = QW - LW;
  localparam int unsigned LPW  = LW + 1 + D;
  localparam int unsigned HPW  = HW + D;
  localparam int unsigned NW   = 3 * D + 2;
  localparam int unsigned MW   = NW - 1;
  localparam int unsigned DENW = 2 * CW + 1;
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  ctl_t ctl1_d, ctl3_d;

  // stage 1
  logic [CW-1:0] sax, say, sbx, sby, dax, day, dbx, dby;
  logic signed [D-1:0] ax1_q, ay1_q, cx1_q, cy1_q, dx1_q, dy1_q;
  logic [CW-1:0] dax1_q, day1_q;
  logic unset;

  always_comb begin
    unset = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (pins_i[i] == CMIN) unset = 1'b1;
    end
    if (op_i) begin
      sax = pins_i[REG_CUR_A_X]; say = pins_i[REG_CUR_A_Y];
      sbx = pins_i[REG_CUR_B_X]; sby = pins_i[REG_CUR_B_Y];
      dax = pins_i[REG_LOC_A_X]; day = pins_i[REG_LOC_A_Y];
      dbx = pins_i[REG_LOC_B_X]; dby = pins_i[REG_LOC_B_Y];
    end else begin
      sax = pins_i[REG_LOC_A_X]; say = pins_i[REG_LOC_A_Y];
      sbx = pins_i[REG_LOC_B_X]; sby = pins_i[REG_LOC_B_Y];
      dax = pins_i[REG_CUR_A_X]; day = pins_i[REG_CUR_A_Y];
      dbx = pins_i[REG_CUR_B_X]; dby = pins_i[REG_CUR_B_Y];
    end
    ctl1_d.valid  = valid_i;
    ctl1_d.status = unset ? ST_UNSET : ST_OK;
  end

  // stage 2
  logic signed [PW-1:0] axcx2_q, aycy2_q, axcy2_q, aycx2_q, dxdx2_q, dydy2_q;
  logic signed [D-1:0]  dx2_q, dy2_q;
  logic [CW-1:0]        dax2_q, day2_q;

  // stage 3
  logic signed [QW-1:0] qx3_q, qy3_q;
  logic signed [D-1:0]  dx3_q, dy3_q;
  logic [DENW-1:0]      den3_q;
  logic [DENW-1:0]      den3_d;
  logic [CW-1:0]        dax3_q, day3_q;

  // stage 4
  logic signed [HPW-1:0] hxdx4_q, hydy4_q, hydx4_q, hxdy4_q;
  logic signed [LPW-1:0] lxdx4_q, lydy4_q, lydx4_q, lxdy4_q;
  logic [DENW-1:0]       den4_q;
  logic [CW-1:0]         dax4_q, day4_q;
  logic signed [HW-1:0]  qxh, qyh;
  logic signed [LW:0]    qxl, qyl;

  // stage 5
  logic signed [NW-1:0] nx5_q, ny5_q;
  logic [DENW-1:0]      den5_q;
  logic [CW-1:0]        dax5_q, day5_q;

  // stage 6
  logic [MW-1:0]   nxm6_q, nym6_q;
  logic            nxn6_q, nyn6_q;
  logic [DENW-1:0] den6_q;
  logic [CW-1:0]   dax6_q, day6_q;

  always_comb begin
    den3_d = DENW'(dxdx2_q) + DENW'(dydy2_q);
    ctl3_d = ctl2_q;
    if (ctl2_q.status == ST_OK && den3_d == '0) ctl3_d.status = ST_ZERO;
    qxh = qx3_q[QW-1:LW];
    qyh = qy3_q[QW-1:LW];
    qxl = signed'({1'b0, qx3_q[LW-1:0]});
    qyl = signed'({1'b0, qy3_q[LW-1:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0; ctl2_q <= '0; ctl3_q <= '0;
      ctl4_q <= '0; ctl5_q <= '0; ctl6_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl1_d; ctl2_q <= ctl1_q; ctl3_q <= ctl3_d;
      ctl4_q <= ctl3_q; ctl5_q <= ctl4_q; ctl6_q <= ctl5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= D'(signed'(px_i)) - D'(signed'(sax));
      ay1_q  <= D'(signed'(py_i)) - D'(signed'(say));
      cx1_q  <= D'(signed'(dbx)) - D'(signed'(dax));
      cy1_q  <= D'(signed'(dby)) - D'(signed'(day));
      dx1_q  <= D'(signed'(sbx)) - D'(signed'(sax));
      dy1_q  <= D'(signed'(sby)) - D'(signed'(say));
      dax1_q <= dax;
      day1_q <= day;

      axcx2_q <= ax1_q * cx1_q;
      aycy2_q <= ay1_q * cy1_q;
      axcy2_q <= ax1_q * cy1_q;
      aycx2_q <= ay1_q * cx1_q;
      dxdx2_q <= dx1_q * dx1_q;
      dydy2_q <= dy1_q * dy1_q;
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      dax2_q  <= dax1_q;
      day2_q  <= day1_q;

      qx3_q  <= QW'(axcx2_q) - QW'(aycy2_q);
      qy3_q  <= QW'(axcy2_q) + QW'(aycx2_q);
      den3_q <= den3_d;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      dax3_q <= dax2_q;
      day3_q <= day2_q;

      // split q into signed high and unsigned low halves
      hxdx4_q <= qxh * dx3_q;
      lxdx4_q <= LPW'(qxl * dx3_q);
      hydy4_q <= qyh * dy3_q;
      lydy4_q <= LPW'(qyl * dy3_q);
      hydx4_q <= qyh * dx3_q;
      lydx4_q <= LPW'(qyl * dx3_q);
      hxdy4_q <= qxh * dy3_q;
      lxdy4_q <= LPW'(qxl * dy3_q);
      den4_q  <= den3_q;
      dax4_q  <= dax3_q;
      day4_q  <= day3_q;

      nx5_q  <= (NW'(hxdx4_q) <<< LW) + NW'(lxdx4_q)
              + (NW'(hydy4_q) <<< LW) + NW'(lydy4_q);
      ny5_q  <= (NW'(hydx4_q) <<< LW) + NW'(lydx4_q)
              - (NW'(hxdy4_q) <<< LW) - NW'(lxdy4_q);
      den5_q <= den4_q;
      dax5_q <= dax4_q;
      day5_q <= day4_q;

      nxn6_q <= nx5_q[NW-1];
      nyn6_q <= ny5_q[NW-1];
      nxm6_q <= nx5_q[NW-1] ? MW'(-nx5_q) : MW'(nx5_q);
      nym6_q <= ny5_q[NW-1] ? MW'(-ny5_q) : MW'(ny5_q);
      den6_q <= den5_q;
      dax6_q <= dax5_q;
      day6_q <= day5_q;
    end
  end

  assign ctl_o    = ctl6_q;
  assign nx_neg_o = nxn6_q;
  assign nx_mag_o = nxm6_q;
  assign ny_neg_o = nyn6_q;
  assign ny_mag_o = nym6_q;
  assign den_o    = den6_q;
  assign dax_o    = dax6_q;
  assign day_o    = day6_q;

endmodule

`default_nettype wire

>>> hw/rtl/tpst_div.sv
// Pipelined restoring divider for both coordinates, one quotient bit per stage.
// Rounds half away from zero and flags quotients too large for the output. Uses tpst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpst_div #(
  parameter int unsigned CW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tpst_pkg::ctl_t    ctl_i,
  input  logic              nx_neg_i,
  input  logic [3*CW+3:0]   nx_mag_i,
  input  logic              ny_neg_i,
  input  logic [3*CW+3:0]   ny_mag_i,
  input  logic [2*CW:0]     den_i,
  input  logic [CW-1:0]     dax_i,
  input  logic [CW-1:0]     day_i,
  output tpst_pkg::ctl_t    ctl_o,
  output logic              x_neg_o,
  output logic [CW+3:0]     x_mag_o,
  output logic              y_neg_o,
  output logic [CW+3:0]     y_mag_o,
  output logic [CW-1:0]     dax_o,
  output logic [CW-1:0]     day_o
);
  import tpst_pkg::*;

  localparam int unsigned Q    = CW + 3;
  localparam int unsigned QB   = Q + 1;
  localparam int unsigned MW   = 3 * CW + 4;
  localparam int unsigned DENW = 2 * CW + 1;

  ctl_t            ctl_q  [Q+1];
  logic [MW-1:0]   rx_q   [Q+1];
  logic [MW-1:0]   ry_q   [Q+1];
  logic [Q-1:0]    qx_q   [Q+1];
  logic [Q-1:0]    qy_q   [Q+1];
  logic [DENW-1:0] den_q  [Q+1];
  logic [CW-1:0]   dax_q  [Q+1];
  logic [CW-1:0]   day_q  [Q+1];
  logic            xn_q   [Q+1];
  logic            yn_q   [Q+1];
  logic            xo_q   [Q+1];
  logic            yo_q   [Q+1];

  ctl_t            fctl_q;
  logic [QB-1:0]   fx_q, fy_q;
  logic            fxn_q, fyn_q;
  logic [CW-1:0]   fdax_q, fday_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Q; i++) ctl_q[i] <= '0;
      fctl_q <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i <= Q; i++) ctl_q[i] <= ctl_q[i-1];
      fctl_q <= ctl_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]  <= nx_mag_i;
      ry_q[0]  <= ny_mag_i;
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      den_q[0] <= den_i;
      dax_q[0] <= dax_i;
      day_q[0] <= day_i;
      xn_q[0]  <= nx_neg_i;
      yn_q[0]  <= ny_neg_i;
      xo_q[0]  <= nx_mag_i >= (MW'(den_i) << Q);
      yo_q[0]  <= ny_mag_i >= (MW'(den_i) << Q);
    end
  end

  for (genvar j = 0; j < Q; j++) begin : g_stage
    localparam int unsigned K = Q - 1 - j;
    logic [MW-1:0] dsh;
    logic          bx, by;
    assign dsh = MW'(den_q[j]) << K;
    assign bx  = rx_q[j] >= dsh;
    assign by  = ry_q[j] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j+1]  <= bx ? rx_q[j] - dsh : rx_q[j];
        ry_q[j+1]  <= by ? ry_q[j] - dsh : ry_q[j];
        qx_q[j+1]  <= {qx_q[j][Q-2:0], bx};
        qy_q[j+1]  <= {qy_q[j][Q-2:0], by};
        den_q[j+1] <= den_q[j];
        dax_q[j+1] <= dax_q[j];
        day_q[j+1] <= day_q[j];
        xn_q[j+1]  <= xn_q[j];
        yn_q[j+1]  <= yn_q[j];
        xo_q[j+1]  <= xo_q[j];
        yo_q[j+1]  <= yo_q[j];
      end
    end
  end

  logic rnd_x, rnd_y;
  assign rnd_x = ((DENW+1)'(rx_q[Q]) << 1) >= (DENW+1)'(den_q[Q]);
  assign rnd_y = ((DENW+1)'(ry_q[Q]) << 1) >= (DENW+1)'(den_q[Q]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q   <= xo_q[Q] ? (QB'(1) << Q) : QB'(qx_q[Q]) + QB'(rnd_x);
      fy_q   <= yo_q[Q] ? (QB'(1) << Q) : QB'(qy_q[Q]) + QB'(rnd_y);
      fxn_q  <= xn_q[Q];
      fyn_q  <= yn_q[Q];
      fdax_q <= dax_q[Q];
      fday_q <= day_q[Q];
    end
  end

  assign ctl_o   = fctl_q;
  assign x_neg_o = fxn_q;
  assign x_mag_o = fx_q;
  assign y_neg_o = fyn_q;
  assign y_mag_o = fy_q;
  assign dax_o   = fdax_q;
  assign day_o   = fday_q;

endmodule

`default_nettype wire

>>> hw/rtl/tpst_skid.sv
// Two-entry output queue that decouples the pipeline from the result receiver.
// Full flag is registered and stalls the whole pipeline. Standalone.
`timescale 1ns / 1ps
`default_nettype none

module tpst_skid #(
  parameter int unsigned W = 66
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic [1:0]   count_q, count_d;
  logic         wr_q, rd_q;
  logic         pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    count_d = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_full_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && ready_i) |=> !full_o) else $error("full queue did not drain");
`endif

endmodule

`default_nettype wire

>>> test/tb_two_pin_similarity_transform.sv
// Testbench for two_pin_similarity_transform: directed table then random points, each result
// checked against its table row or an exact-arithmetic predictor. Uses tpst_pkg and the RTL.
`timescale 1ns / 1ps

module tb_two_pin_similarity_transform;
  import tpst_pkg::*;

  localparam int CW = 32;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam int LAT = CW + 12;
  localparam longint LIMIT = 2_000_000;

  typedef struct {
    logic op;
    logic signed [31:0] px, py;
    logic chk;
    logic signed [31:0] ex, ey;
    status_e st;
  } row_t;

  typedef struct {
    logic signed [31:0] x, y;
    status_e st;
  } map_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // point_x, point_y
  logic s_axis_tuser = 0;          // operation
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [63:0] m_axis_tdata;       // mapped_x, mapped_y
  logic [1:0] m_axis_tuser;        // status

  two_pin_similarity_transform #(.COORD_WIDTH(CW)) u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  logic signed [31:0] pins [8];
  map_t expected_maps [$];
  int errors = 0;
  longint cyc = 0;
  int src_idle = 0, snk_idle = 0;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // divide rounding half away from zero, clamped to +-2^62
  function automatic longint div_round(logic signed [255:0] n, logic signed [255:0] d);
    logic signed [255:0] m, q, r;
    logic neg;
    neg = n < 0;
    m = neg ? -n : n;
    q = m / d;
    r = m % d;
    if (2 * r >= d) q = q + 1;
    if (q > (256'sd1 <<< 62)) q = 256'sd1 <<< 62;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clip(longint v, inout logic sat);
    if (v > longint'(CMAX)) begin sat = 1; return CMAX; end
    if (v < longint'(CMIN)) begin sat = 1; return CMIN; end
    return v[31:0];
  endfunction

  function automatic map_t map_point(logic op, logic signed [31:0] px, logic signed [31:0] py);
    map_t m;
    logic signed [255:0] sax, say, sbx, sby, dax, day, dbx, dby;
    logic signed [255:0] dx, dy, den, ax, ay, cx, cy, qx, qy, nx, ny;
    logic sat;
    sat = 0;
    m.x = CMIN; m.y = CMIN;
    foreach (pins[i]) if (pins[i] == CMIN) begin m.st = ST_UNSET; return m; end
    if (!op) begin
      sax = pins[0]; say = pins[1]; sbx = pins[2]; sby = pins[3];
      dax = pins[4]; day = pins[5]; dbx = pins[6]; dby = pins[7];
    end else begin
      sax = pins[4]; say = pins[5]; sbx = pins[6]; sby = pins[7];
      dax = pins[0]; day = pins[1]; dbx = pins[2]; dby = pins[3];
    end
    dx = sbx - sax; dy = sby - say;
    den = dx * dx + dy * dy;
    if (den == 0) begin m.st = ST_ZERO; return m; end
    ax = px - sax; ay = py - say; cx = dbx - dax; cy = dby - day;
    qx = ax * cx - ay * cy; qy = ax * cy + ay * cx;
    nx = qx * dx + qy * dy; ny = qy * dx - qx * dy;
    m.x = clip(div_round(nx, den) + longint'(dax), sat);
    m.y = clip(div_round(ny, den) + longint'(day), sat);
    m.st = sat ? ST_SAT : ST_OK;
    return m;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
      if (m_axis_tvalid && m_axis_tready) begin
        map_t e;
        if (expected_maps.size() == 0) begin
          $display("%0t unexpected result %h/%0d", $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          e = expected_maps.pop_front();
          if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
              m_axis_tuser !== e.st) begin
            $display("%0t mismatch exp x=%h y=%h st=%0d got x=%h y=%h st=%0d", $time,
                     e.x, e.y, e.st, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_pin(reg_idx_e idx, logic signed [31:0] v);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pins[idx] = v;
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_pins(logic signed [31:0] v [8]);
    for (int i = 0; i < 8; i++) write_pin(reg_idx_e'(i), v[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  // tvalid stays high after an accept so the next item can follow in the next cycle;
  // idling or drain() drops it
  task automatic send_point(row_t r);
    map_t e;
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1; s_axis_tuser <= r.op; s_axis_tdata <= {r.py, r.px};
    do @(posedge clk_i); while (!s_axis_tready);
    e = map_point(r.op, r.px, r.py);
    if (r.chk && (e.x !== r.ex || e.y !== r.ey || e.st !== r.st))
      $display("%0t table row disagrees with predictor", $time);
    if (r.chk) begin e.x = r.ex; e.y = r.ey; e.st = r.st; end
    expected_maps.push_back(e);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? CMAX : CMIN + 1;
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  row_t tbl [$];
  logic signed [31:0] cfg_v [8];

  initial begin
    foreach (pins[i]) pins[i] = CMIN;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // after reset every pin is unset
    tbl = '{
      '{0, 32'sd0, 32'sd0, 1, CMIN, CMIN, ST_UNSET},
      '{1, CMAX, CMIN, 1, CMIN, CMIN, ST_UNSET}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();

    // identity with unit spacing, then one pin still unset
    cfg_v = '{0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
    set_pins(cfg_v);
    tbl = '{
      '{0, 32'sd5, -32'sd7, 1, 32'sd5, -32'sd7, ST_OK},
      '{1, CMAX, CMAX, 1, CMAX, CMAX, ST_OK},
      '{0, CMIN, CMIN + 1, 1, CMIN, CMIN + 1, ST_OK},
      '{1, -32'sd1, 32'sh1234, 0, 0, 0, ST_OK}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();
    write_pin(REG_CUR_B_Y, CMIN);
    tbl = '{'{0, 32'sd1, 32'sd1, 1, CMIN, CMIN, ST_UNSET}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();

    // coincident source pins, then scale by 2 with saturation
    cfg_v = '{32'sd9, 32'sd9, 32'sd9, 32'sd9, 0, 0, 32'sd4, 0};
    set_pins(cfg_v);
    tbl = '{'{0, 32'sd3, 32'sd3, 1, CMIN, CMIN, ST_ZERO},
            '{1, 32'sd3, 32'sd3, 0, 0, 0, ST_OK}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();
    cfg_v = '{0, 0, 32'sd1, 0, 0, 0, 32'sd2, 0};
    set_pins(cfg_v);
    tbl = '{
      '{0, CMAX, -32'sd3, 1, CMAX, -32'sd6, ST_SAT},
      '{0, CMIN, 32'sd0, 1, CMIN, 32'sd0, ST_SAT},
      '{1, 32'sd3, -32'sd3, 0, 0, 0, ST_OK},
      '{0, 32'sd0, 32'sd0, 0, 0, 0, ST_OK}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();
    // coincident destination pins; extreme pins
    cfg_v = '{0, 0, 32'sd8, 32'sd3, 32'sd11, -32'sd2, 32'sd11, -32'sd2};
    set_pins(cfg_v);
    tbl = '{'{0, 32'sd77, CMAX, 1, 32'sd11, -32'sd2, ST_OK},
            '{1, 32'sd1, 32'sd1, 1, CMIN, CMIN, ST_ZERO}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();
    cfg_v = '{CMAX, CMIN + 1, CMIN + 1, CMAX, CMIN + 1, CMAX, CMAX, CMIN + 1};
    set_pins(cfg_v);
    tbl = '{'{0, CMAX, CMIN, 0, 0, 0, ST_OK}, '{1, CMIN + 1, CMAX, 0, 0, 0, ST_OK},
            '{0, 32'sd0, -32'sd1, 0, 0, 0, ST_OK}};
    foreach (tbl[i]) send_point(tbl[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = ph == 0 ? 38 : ph == 1 ? 61 : 0;
      snk_idle = ph == 0 ? 61 : ph == 1 ? 38 : 0;
      for (int s = 0; s < 10; s++) begin
        for (int i = 0; i < 8; i++) cfg_v[i] = rnd_coord();
        if ($urandom_range(9) == 0) cfg_v[$urandom_range(7)] = CMIN;
        if ($urandom_range(9) == 0) begin cfg_v[6] = cfg_v[4]; cfg_v[7] = cfg_v[5]; end
        set_pins(cfg_v);
        for (int n = 0; n < 67; n++) begin
          row_t r;
          r.op = $urandom_range(1); r.px = rnd_coord(); r.py = rnd_coord();
          if ($urandom_range(15) == 0) r.px = CMIN;
          r.chk = 0;
          send_point(r);
          if (ph == 2 && $urandom_range(3) == 0) src_idle = 0;
        end
        drain();
      end
    end

    drain();
    if (errors == 0 && expected_maps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
